[hdl/cdas_pkg.sv]
// Shared types, constants and the month-length table for the date add/subtract block.
// No dependencies; every other file in hdl/ imports this package.
package cdas_pkg;

    localparam int COUNT_WIDTH = 20;  // bits of the day count that take part in the walk
    localparam int YEAR_W      = 14;
    localparam int CENT_W      = 8;   // year / 100, at most 163
    localparam int YIC_W       = 7;   // year % 100

    localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(9999);
    localparam logic [YIC_W-1:0]  YIC_LAST = YIC_W'(99);
    localparam logic [6:0]        YEARS_PER_CENT = 7'd100;

    // year / 100 == (year * RECIP) >> RECIP_SHIFT for every 14-bit year
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(5243);
    localparam int PROD_W      = YEAR_W + RECIP_W;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SPLIT,
        S_CHECK,
        S_WALK,
        S_RELOAD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              mode;
        logic [4:0]        day_in;
        logic [3:0]        month_in;
        logic [YEAR_W-1:0] year_in;
        logic [19:0]       day_count;
    } t_item;

    typedef struct packed {
        logic [4:0]        day_out;
        logic [3:0]        month_out;
        logic [YEAR_W-1:0] year_out;
        t_status           status;
    } t_result;

    // Last day of a month; 0 for a month code outside 1..12.
    function automatic logic [4:0] month_last_day(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

[hdl/calendar_date_add_subtract.sv]
// Top level: Gregorian date plus/minus a day count, walked one month per step.
// Depends on cdas_pkg and cdas_month_len.
//
//  channel   ports                      handshake
//  -------   -------------------------  ----------------------------------------
//  item in   start, i_item (t_item)     taken at the edge where start & !busy
//  result    o_done, o_result (t_result) one-cycle strobe, no backpressure
//
// Steps: setup (reciprocal multiply, year split, date check), then a walk step per
// month crossed when adding, or a step and a reload of the new month's length per
// month crossed when subtracting, a step for a final partial month, one that finds
// the count spent, and the result state. An invalid date goes from the check straight
// to the result state. The shared subtract/compare on the day count sets the pace.
// Reset returns the sequencer to idle; busy stays high from acceptance until the
// result strobe, and the result cannot be stalled.
module calendar_date_add_subtract (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  cdas_pkg::t_item     i_item,
    output logic                busy,
    output logic                o_done,
    output cdas_pkg::t_result   o_result
);
    import cdas_pkg::*;

    t_state r_state, n_state;

    t_item                  r_item;
    logic [COUNT_WIDTH-1:0] r_num,   n_num;
    logic [4:0]             r_day,   n_day;
    logic [3:0]             r_month, n_month;
    logic [YEAR_W-1:0]      r_year,  n_year;
    logic [CENT_W-1:0]      r_cent,  n_cent;
    logic [YIC_W-1:0]       r_yic,   n_yic;
    logic [PROD_W-1:0]      r_prod;
    t_status                r_status, n_status;

    logic [4:0]             w_last;
    logic [5:0]             w_opnd;
    logic [COUNT_WIDTH:0]   w_diff;
    logic                   w_take;
    logic                   w_valid;
    logic                   w_year_zero;
    logic [CENT_W-1:0]      w_q;

    cdas_month_len u_mlen (
        .i_month (r_month),
        .i_cent  (r_cent),
        .i_yic   (r_yic),
        .o_last  (w_last)
    );

    // Shared step unit: the day count against the days to the month boundary.
    // Add: boundary is last-d+1 days ahead. Subtract: d days back to the previous month.
    assign w_opnd = r_item.mode ? {1'b0, r_day}
                                : ({1'b0, w_last} - {1'b0, r_day} + 6'd1);
    assign w_diff = {1'b0, r_num} - (COUNT_WIDTH+1)'(w_opnd);
    assign w_take = ~w_diff[COUNT_WIDTH];

    assign w_valid = (r_month >= MONTH_JAN) && (r_month <= MONTH_DEC)
                  && (r_day != 5'd0) && (r_day <= w_last);
    assign w_year_zero = (r_cent == '0) && (r_yic == '0);
    assign w_q = r_prod[RECIP_SHIFT +: CENT_W];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (start) n_state = S_DIV;
            S_DIV:    n_state = S_SPLIT;
            S_SPLIT:  n_state = S_CHECK;
            S_CHECK:  n_state = w_valid ? S_WALK : S_DONE;
            S_WALK: begin
                if (r_num == '0) begin
                    n_state = S_DONE;
                end else if (!r_item.mode) begin
                    if (r_year > YEAR_MAX) n_state = S_DONE;
                end else if (w_take) begin
                    if (r_month == MONTH_JAN && w_year_zero) n_state = S_DONE;
                    else n_state = S_RELOAD;
                end
            end
            S_RELOAD: n_state = S_WALK;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_num    = r_num;
        n_day    = r_day;
        n_month  = r_month;
        n_year   = r_year;
        n_cent   = r_cent;
        n_yic    = r_yic;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                n_num    = COUNT_WIDTH'(i_item.day_count);
                n_day    = i_item.day_in;
                n_month  = i_item.month_in;
                n_year   = i_item.year_in;
                n_status = ST_OK;
            end
            S_SPLIT: begin
                n_cent = w_q;
                n_yic  = YIC_W'(r_year - YEAR_W'(w_q) * YEAR_W'(YEARS_PER_CENT));
            end
            S_CHECK: begin
                if (!w_valid) n_status = ST_BAD_DATE;
            end
            S_WALK: begin
                if (r_num == '0 || (!r_item.mode && r_year > YEAR_MAX)) begin
                    n_status = (r_year > YEAR_MAX) ? ST_RANGE : ST_OK;
                end else if (!r_item.mode) begin
                    if (w_take) begin
                        n_num = w_diff[COUNT_WIDTH-1:0];
                        n_day = 5'd1;
                        if (r_month == MONTH_DEC) begin
                            n_month = MONTH_JAN;
                            n_year  = r_year + YEAR_W'(1);
                            if (r_yic == YIC_LAST) begin
                                n_yic  = '0;
                                n_cent = r_cent + CENT_W'(1);
                            end else begin
                                n_yic = r_yic + YIC_W'(1);
                            end
                        end else begin
                            n_month = r_month + 4'd1;
                        end
                    end else begin
                        n_day = r_day + r_num[4:0];
                        n_num = '0;
                    end
                end else begin
                    if (w_take) begin
                        n_num = w_diff[COUNT_WIDTH-1:0];
                        if (r_month == MONTH_JAN) begin
                            n_month = MONTH_DEC;
                            if (w_year_zero) begin
                                // walked below year 0
                                n_status = ST_RANGE;
                            end else begin
                                n_year = r_year - YEAR_W'(1);
                                if (r_yic == '0) begin
                                    n_yic  = YIC_LAST;
                                    n_cent = r_cent - CENT_W'(1);
                                end else begin
                                    n_yic = r_yic - YIC_W'(1);
                                end
                            end
                        end else begin
                            n_month = r_month - 4'd1;
                        end
                    end else begin
                        n_day = r_day - r_num[4:0];
                        n_num = '0;
                    end
                end
            end
            S_RELOAD: n_day = w_last;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) r_item <= i_item;
        r_prod   <= r_year * RECIP;
        r_num    <= n_num;
        r_day    <= n_day;
        r_month  <= n_month;
        r_year   <= n_year;
        r_cent   <= n_cent;
        r_yic    <= n_yic;
        r_status <= n_status;
    end

    // outputs
    always_comb begin
        busy     = (r_state != S_IDLE);
        o_done   = (r_state == S_DONE);
        o_result.status = r_status;
        if (r_status == ST_OK) begin
            o_result.day_out   = r_day;
            o_result.month_out = r_month;
            o_result.year_out  = r_year;
        end else begin
            o_result.day_out   = r_item.day_in;
            o_result.month_out = r_item.month_in;
            o_result.year_out  = r_item.year_in;
        end
    end

    a_walk_day_in_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_day != 5'd0 && r_day <= w_last))
        else $error("day left its month during the walk");

    a_walk_month_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK || r_state == S_RELOAD) |->
        (r_month >= MONTH_JAN && r_month <= MONTH_DEC))
        else $error("month out of 1..12 during the walk");

    a_split_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |->
        (r_yic < YIC_W'(YEARS_PER_CENT)
         && YEAR_W'(r_cent) * YEAR_W'(YEARS_PER_CENT) + YEAR_W'(r_yic) == r_year))
        else $error("year split into century and remainder is wrong");

    a_ok_result_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_OK) |->
        (o_result.month_out >= MONTH_JAN && o_result.month_out <= MONTH_DEC
         && o_result.day_out != 5'd0 && o_result.year_out <= YEAR_MAX))
        else $error("good status with an impossible date");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted item did not start the sequencer");

endmodule

[hdl/cdas_month_len.sv]
// Month length lookup with the 400/100/4 leap rule on a split year (century, year in century).
// Depends on cdas_pkg.
module cdas_month_len (
    input  logic [3:0]               i_month,
    input  logic [cdas_pkg::CENT_W-1:0] i_cent,
    input  logic [cdas_pkg::YIC_W-1:0]  i_yic,
    output logic [4:0]               o_last
);
    import cdas_pkg::*;

    logic w_leap;

    // century years are leap only when the century number is a multiple of 4
    assign w_leap = (i_yic == '0) ? (i_cent[1:0] == 2'b00) : (i_yic[1:0] == 2'b00);
    assign o_last = month_last_day(i_month, w_leap);

endmodule

[dv/testbench.sv]
// Self-checking bench for calendar_date_add_subtract: directed corner dates, then random requests.
// Depends on cdas_pkg (t_item, t_result, t_status, COUNT_WIDTH, YEAR_MAX) and the block's RTL.
module testbench;
    import cdas_pkg::*;

    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PRINT_LIMIT  = 40;
    localparam int FULL_COUNT   = 1048575;

    class date_scoreboard;
        t_result expected_dates[$];
        int      errors;

        function new();
            errors = 0;
        endfunction

        static function bit is_leap(int y);
            int unsigned u;
            u = y;
            if (u % 400 == 0) return 1'b1;
            if (u % 100 == 0) return 1'b0;
            return (u % 4) == 0;
        endfunction

        static function int days_in_month(int m, int y);
            int len;
            case (m)
                1, 3, 5, 7, 8, 10, 12: len = 31;
                4, 6, 9, 11:           len = 30;
                2:                     len = is_leap(y) ? 29 : 28;
                default:               len = 0;
            endcase
            return len;
        endfunction

        // Walk the date one month at a time, the same way the block does.
        static function t_result shift_date(t_item rq);
            t_result         res;
            t_status         st;
            int              d, m, y, last, ymax;
            longint unsigned left;
            d    = int'(rq.day_in);
            m    = int'(rq.month_in);
            y    = int'(rq.year_in);
            ymax = int'(YEAR_MAX);
            left = longint'(rq.day_count) & ((64'd1 << COUNT_WIDTH) - 1);
            st   = ST_OK;
            if (m < 1 || m > 12 || d < 1 || d > days_in_month(m, y)) begin
                st = ST_BAD_DATE;
            end else if (!rq.mode) begin
                while (left > 0 && y <= ymax) begin
                    last = days_in_month(m, y);
                    if (left > longint'(last - d)) begin
                        left -= longint'(last - d + 1);
                        d = 1;
                        m++;
                    end else begin
                        d += int'(left);
                        left = 0;
                    end
                    if (m > 12) begin
                        m = 1;
                        y++;
                    end
                end
                if (y > ymax) st = ST_RANGE;
            end else begin
                while (left > 0 && y >= 0) begin
                    if (left >= longint'(d)) begin
                        left -= longint'(d);
                        m--;
                        if (m < 1) begin
                            m = 12;
                            y--;
                        end
                        if (y < 0) break;
                        d = days_in_month(m, y);
                    end else begin
                        d -= int'(left);
                        left = 0;
                    end
                end
                if (y < 0 || y > ymax) st = ST_RANGE;
            end
            // any failure echoes the request date as given
            if (st != ST_OK) begin
                d = int'(rq.day_in);
                m = int'(rq.month_in);
                y = int'(rq.year_in);
            end
            res.day_out   = d[4:0];
            res.month_out = m[3:0];
            res.year_out  = y[YEAR_W-1:0];
            res.status    = st;
            return res;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_LIMIT) $display("mismatch: %s", msg);
        endtask

        function int pending();
            return expected_dates.size();
        endfunction

        task note_request(t_item rq);
            expected_dates.push_back(shift_date(rq));
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_dates.size() == 0) begin
                report($sformatf("unexpected result %0d-%0d-%0d status %0d",
                                 got.year_out, got.month_out, got.day_out, got.status));
            end else begin
                want = expected_dates.pop_front();
                if (got.day_out !== want.day_out)
                    report($sformatf("day_out %0d, want %0d", got.day_out, want.day_out));
                if (got.month_out !== want.month_out)
                    report($sformatf("month_out %0d, want %0d", got.month_out, want.month_out));
                if (got.year_out !== want.year_out)
                    report($sformatf("year_out %0d, want %0d", got.year_out, want.year_out));
                if (got.status !== want.status)
                    report($sformatf("status %0d, want %0d", got.status, want.status));
            end
        endtask
    endclass

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    t_item   i_item;
    logic    busy;
    logic    o_done;
    t_result o_result;

    date_scoreboard sb;
    int             cycle_count = 0;

    calendar_date_add_subtract dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_result);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_item date_req(logic mode, int d, int m, int y, int cnt);
        t_item rq;
        rq.mode      = mode;
        rq.day_in    = 5'(d);
        rq.month_in  = 4'(m);
        rq.year_in   = YEAR_W'(y);
        rq.day_count = 20'(cnt);
        return rq;
    endfunction

    // Present one item, hold it until taken, then maybe leave a gap.
    // With no gap start stays high so the next item follows back to back.
    task send_date_request(t_item rq);
        int gap, sel;
        start  <= 1'b1;
        i_item <= rq;
        do @(posedge i_clk); while (busy);
        sb.note_request(rq);
        sel = $urandom_range(0, 99);
        if (sel < 40)      gap = 0;
        else if (sel < 90) gap = $urandom_range(1, 4);
        else               gap = $urandom_range(10, 60);
        if (gap > 0) begin
            start  <= 1'b0;
            i_item <= t_item'({$urandom, $urandom});
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        t_item rq;
        int    sel, last;
        sb = new();
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // leap rule, month and year wraps, zero count
        send_date_request(date_req(1'b0, 28, 2, 2024, 1));
        send_date_request(date_req(1'b0, 28, 2, 2023, 1));
        send_date_request(date_req(1'b0, 28, 2, 1900, 1));
        send_date_request(date_req(1'b0, 28, 2, 2000, 1));
        send_date_request(date_req(1'b0, 29, 2, 0, 365));
        send_date_request(date_req(1'b1, 1, 3, 2000, 1));
        send_date_request(date_req(1'b1, 1, 3, 1900, 1));
        send_date_request(date_req(1'b0, 31, 12, 2023, 1));
        send_date_request(date_req(1'b1, 1, 1, 2024, 1));
        send_date_request(date_req(1'b0, 17, 5, 2024, 0));
        // invalid dates
        send_date_request(date_req(1'b0, 10, 0, 2020, 5));
        send_date_request(date_req(1'b1, 10, 13, 2020, 5));
        send_date_request(date_req(1'b1, 31, 15, 16383, FULL_COUNT));
        send_date_request(date_req(1'b0, 0, 6, 2020, 5));
        send_date_request(date_req(1'b0, 31, 4, 2023, 5));
        send_date_request(date_req(1'b1, 29, 2, 1900, 5));
        send_date_request(date_req(1'b0, 30, 2, 2000, 5));
        // year range, including a start year above the limit
        send_date_request(date_req(1'b0, 31, 12, 9999, 1));
        send_date_request(date_req(1'b1, 1, 1, 0, 1));
        send_date_request(date_req(1'b0, 1, 1, 10000, 0));
        send_date_request(date_req(1'b1, 15, 6, 12000, FULL_COUNT));
        // full count, with and without stopping early
        send_date_request(date_req(1'b0, 1, 1, 0, FULL_COUNT));
        send_date_request(date_req(1'b1, 31, 12, 9999, FULL_COUNT));
        send_date_request(date_req(1'b0, 1, 1, 9000, FULL_COUNT));
        send_date_request(date_req(1'b1, 1, 1, 2000, FULL_COUNT));

        for (int n = 0; n < 1600; n++) begin
            rq.mode = 1'($urandom_range(0, 1));
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                rq.day_in   = 5'($urandom_range(0, 31));
                rq.month_in = 4'($urandom_range(0, 15));
                rq.year_in  = YEAR_W'($urandom_range(0, 16383));
            end else begin
                rq.month_in = 4'($urandom_range(1, 12));
                sel = $urandom_range(0, 99);
                if (sel < 6)       rq.year_in = YEAR_W'($urandom_range(0, 3));
                else if (sel < 12) rq.year_in = YEAR_W'($urandom_range(9996, 9999));
                else if (sel < 17) rq.year_in = YEAR_W'($urandom_range(10000, 16383));
                else               rq.year_in = YEAR_W'($urandom_range(0, 9999));
                last = date_scoreboard::days_in_month(int'(rq.month_in), int'(rq.year_in));
                sel = $urandom_range(0, 99);
                if (sel < 30)      rq.day_in = 5'(last - int'($urandom_range(0, 1)));
                else if (sel < 40) rq.day_in = 5'd1;
                else               rq.day_in = 5'($urandom_range(1, last));
            end
            // mostly short walks; a rare full-width count
            sel = $urandom_range(0, 511);
            if (sel == 0)      rq.day_count = 20'($urandom_range(0, FULL_COUNT));
            else if (sel < 40) rq.day_count = 20'($urandom_range(0, 16383));
            else if (sel < 70) rq.day_count = '0;
            else if (sel < 200) rq.day_count = 20'($urandom_range(0, 31));
            else               rq.day_count = 20'($urandom_range(0, 400));
            send_date_request(rq);
        end

        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/cdas_pkg.sv
hdl/cdas_month_len.sv
hdl/calendar_date_add_subtract.sv
dv/testbench.sv
